[rtl/core/i2cm_pkg.sv]
// i2cm_pkg: shared types and codes for the I2C EEPROM transaction master.
// Request and result item structs, request codes, register indexes.
// No dependencies.
package i2cm_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_PHASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONTROL_CODE    = 1'd1;

  localparam logic [7:0] TICKS_RESET = 8'd2;
  localparam logic [3:0] CTRL_RESET  = 4'd10;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_START = 2'd1;
  localparam logic [1:0] REQ_WDATA = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        sda_in;
    logic [2:0]  device_sel;
    logic [15:0] mem_addr;
    logic        is_read;
    logic [15:0] byte_count;
    logic [7:0]  wr_byte;
  } req_item_t;

  typedef struct packed {
    logic       scl;
    logic       sda_drive;
    logic       sda_oe;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       need_data;
    logic       busy_res;
    logic       done_res;
    logic       status;
  } res_item_t;

endpackage

[rtl/core/i2cm_seq.sv]
// i2cm_seq: bus sequencer state and its next-state logic, one item per step.
// The result item is produced combinationally from the updated state.
// Depends on i2cm_pkg.
module i2cm_seq import i2cm_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  req_item_t  req,
  input  logic [7:0] ticks_per_phase,
  input  logic [3:0] control_code,
  output res_item_t  res
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_START = 3'd1;
  localparam logic [2:0] PH_TX    = 3'd2;
  localparam logic [2:0] PH_TXACK = 3'd3;
  localparam logic [2:0] PH_RX    = 3'd4;
  localparam logic [2:0] PH_MACK  = 3'd5;
  localparam logic [2:0] PH_STOP  = 3'd6;

  localparam logic [2:0] K_CTRLW = 3'd0;
  localparam logic [2:0] K_ADDRH = 3'd1;
  localparam logic [2:0] K_ADDRL = 3'd2;
  localparam logic [2:0] K_DATA  = 3'd3;
  localparam logic [2:0] K_CTRLR = 3'd4;

  logic [2:0]  phase, phase_next;
  logic [1:0]  sub_step, sub_step_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [2:0]  byte_kind, byte_kind_next;
  logic [7:0]  shift_reg, shift_reg_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [15:0] addr_reg, addr_reg_next;
  logic [2:0]  sel_reg, sel_reg_next;
  logic        dir_reg, dir_reg_next;
  logic [7:0]  hold_byte, hold_byte_next;
  logic        hold_valid, hold_valid_next;
  logic [7:0]  delay_count, delay_count_next;
  logic        scl_reg, scl_reg_next;
  logic        sda_reg, sda_reg_next;
  logic        oe_reg, oe_reg_next;
  logic        err_flag, err_flag_next;

  logic [7:0]  tpp;
  logic        slot_end;
  logic        stalled;
  logic        new_byte;
  logic [2:0]  new_kind;
  logic        to_stop;
  logic        to_rx;
  logic [7:0]  tx_byte;
  logic [7:0]  rx_byte;
  logic [3:0]  bit_inc;
  logic        rd_valid;
  logic        done;
  logic        status;

  assign tpp      = (ticks_per_phase == 8'd0) ? 8'd1 : ticks_per_phase;
  assign slot_end = ({1'b0, delay_count} + 9'd1) >= {1'b0, tpp};
  assign bit_inc  = bit_index + 4'd1;
  assign tx_byte  = (bit_index == 4'd0 && byte_kind == K_DATA) ? hold_byte : shift_reg;
  assign rx_byte  = {shift_reg[6:0], req.sda_in};

  always_comb begin
    phase_next       = phase;
    sub_step_next    = sub_step;
    bit_index_next   = bit_index;
    byte_kind_next   = byte_kind;
    shift_reg_next   = shift_reg;
    bytes_left_next  = bytes_left;
    addr_reg_next    = addr_reg;
    sel_reg_next     = sel_reg;
    dir_reg_next     = dir_reg;
    hold_byte_next   = hold_byte;
    hold_valid_next  = hold_valid;
    delay_count_next = delay_count;
    scl_reg_next     = scl_reg;
    sda_reg_next     = sda_reg;
    oe_reg_next      = oe_reg;
    err_flag_next    = err_flag;
    stalled          = 1'b0;
    new_byte         = 1'b0;
    new_kind         = K_CTRLW;
    to_stop          = 1'b0;
    to_rx            = 1'b0;
    rd_valid         = 1'b0;
    done             = 1'b0;
    status           = 1'b0;

    case (req.req_type)
      REQ_START: begin
        if (phase == PH_IDLE) begin
          sel_reg_next     = req.device_sel;
          addr_reg_next    = req.mem_addr;
          dir_reg_next     = req.is_read;
          bytes_left_next  = req.byte_count;
          hold_valid_next  = 1'b0;
          err_flag_next    = 1'b0;
          delay_count_next = 8'd0;
          bit_index_next   = 4'd0;
          byte_kind_next   = K_CTRLW;
          phase_next       = PH_START;
          sub_step_next    = 2'd0;
        end
      end
      REQ_WDATA: begin
        if (phase != PH_IDLE && !dir_reg) begin
          hold_byte_next  = req.wr_byte;
          hold_valid_next = 1'b1;
        end
      end
      REQ_TICK: begin
        if (phase != PH_IDLE && !slot_end) begin
          delay_count_next = delay_count + 8'd1;
        end else if (phase != PH_IDLE) begin
          case (phase)
            PH_START: begin
              case (sub_step)
                2'd0: begin
                  oe_reg_next  = 1'b1;
                  sda_reg_next = 1'b1;
                end
                2'd1: scl_reg_next = 1'b1;
                2'd2: sda_reg_next = 1'b0;
                default: begin
                  scl_reg_next = 1'b0;
                  new_byte     = 1'b1;
                  new_kind     = (dir_reg && byte_kind == K_ADDRL) ? K_CTRLR : K_CTRLW;
                end
              endcase
              if (sub_step != 2'd3) begin
                sub_step_next = sub_step + 2'd1;
              end
            end
            PH_TX: begin
              case (sub_step)
                2'd0: begin
                  if (bit_index == 4'd0 && byte_kind == K_DATA && !hold_valid) begin
                    stalled = 1'b1;
                  end else begin
                    if (bit_index == 4'd0 && byte_kind == K_DATA) begin
                      hold_valid_next = 1'b0;
                      bytes_left_next = bytes_left - 16'd1;
                    end
                    shift_reg_next = tx_byte;
                    oe_reg_next    = 1'b1;
                    sda_reg_next   = tx_byte[7];
                    sub_step_next  = 2'd1;
                  end
                end
                2'd1: begin
                  scl_reg_next  = 1'b1;
                  sub_step_next = 2'd2;
                end
                default: begin
                  scl_reg_next   = 1'b0;
                  shift_reg_next = {shift_reg[6:0], 1'b0};
                  bit_index_next = bit_inc;
                  sub_step_next  = 2'd0;
                  if (bit_inc >= 4'd8) begin
                    phase_next     = PH_TXACK;
                    bit_index_next = 4'd0;
                  end
                end
              endcase
            end
            PH_TXACK: begin
              case (sub_step)
                2'd0: begin
                  oe_reg_next   = 1'b0;
                  sub_step_next = 2'd1;
                end
                2'd1: begin
                  scl_reg_next  = 1'b1;
                  sub_step_next = 2'd2;
                end
                default: begin
                  scl_reg_next = 1'b0;
                  if (req.sda_in) begin
                    err_flag_next = 1'b1;
                    to_stop       = 1'b1;
                  end else begin
                    case (byte_kind)
                      K_CTRLW: begin
                        new_byte = 1'b1;
                        new_kind = K_ADDRH;
                      end
                      K_ADDRH: begin
                        new_byte = 1'b1;
                        new_kind = K_ADDRL;
                      end
                      K_ADDRL: begin
                        if (dir_reg) begin
                          phase_next    = PH_START;
                          sub_step_next = 2'd0;
                        end else if (bytes_left == 16'd0) begin
                          to_stop = 1'b1;
                        end else begin
                          new_byte = 1'b1;
                          new_kind = K_DATA;
                        end
                      end
                      K_DATA: begin
                        if (bytes_left == 16'd0) begin
                          to_stop = 1'b1;
                        end else begin
                          new_byte = 1'b1;
                          new_kind = K_DATA;
                        end
                      end
                      default: begin
                        if (bytes_left == 16'd0) begin
                          to_stop = 1'b1;
                        end else begin
                          to_rx = 1'b1;
                        end
                      end
                    endcase
                  end
                end
              endcase
            end
            PH_RX: begin
              case (sub_step)
                2'd0: begin
                  oe_reg_next   = 1'b0;
                  sub_step_next = 2'd1;
                end
                2'd1: begin
                  scl_reg_next  = 1'b1;
                  sub_step_next = 2'd2;
                end
                default: begin
                  shift_reg_next = rx_byte;
                  scl_reg_next   = 1'b0;
                  bit_index_next = bit_inc;
                  sub_step_next  = 2'd0;
                  if (bit_inc >= 4'd8) begin
                    rd_valid        = 1'b1;
                    bytes_left_next = bytes_left - 16'd1;
                    phase_next      = PH_MACK;
                    bit_index_next  = 4'd0;
                  end
                end
              endcase
            end
            PH_MACK: begin
              case (sub_step)
                2'd0: begin
                  oe_reg_next   = 1'b1;
                  sda_reg_next  = (bytes_left == 16'd0);
                  sub_step_next = 2'd1;
                end
                2'd1: begin
                  scl_reg_next  = 1'b1;
                  sub_step_next = 2'd2;
                end
                default: begin
                  scl_reg_next = 1'b0;
                  if (bytes_left == 16'd0) begin
                    to_stop = 1'b1;
                  end else begin
                    to_rx = 1'b1;
                  end
                end
              endcase
            end
            PH_STOP: begin
              case (sub_step)
                2'd0: begin
                  oe_reg_next   = 1'b1;
                  sda_reg_next  = 1'b0;
                  sub_step_next = 2'd1;
                end
                2'd1: begin
                  scl_reg_next  = 1'b1;
                  sub_step_next = 2'd2;
                end
                default: begin
                  sda_reg_next  = 1'b1;
                  phase_next    = PH_IDLE;
                  sub_step_next = 2'd0;
                  done          = 1'b1;
                  status        = err_flag;
                end
              endcase
            end
            default: phase_next = PH_IDLE;
          endcase

          if (new_byte) begin
            byte_kind_next = new_kind;
            phase_next     = PH_TX;
            bit_index_next = 4'd0;
            sub_step_next  = 2'd0;
            case (new_kind)
              K_CTRLW, K_CTRLR:
                shift_reg_next = {control_code, sel_reg, (new_kind == K_CTRLR)};
              K_ADDRH: shift_reg_next = addr_reg[15:8];
              K_ADDRL: shift_reg_next = addr_reg[7:0];
              default: ;
            endcase
          end
          if (to_stop) begin
            phase_next    = PH_STOP;
            sub_step_next = 2'd0;
          end
          if (to_rx) begin
            phase_next     = PH_RX;
            bit_index_next = 4'd0;
            sub_step_next  = 2'd0;
            shift_reg_next = 8'd0;
          end
          delay_count_next = stalled ? (tpp - 8'd1) : 8'd0;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    res.scl       = scl_reg_next;
    res.sda_drive = sda_reg_next;
    res.sda_oe    = oe_reg_next;
    res.rd_valid  = rd_valid;
    res.rd_byte   = rd_valid ? rx_byte : 8'd0;
    res.need_data = (phase_next == PH_TX) && (byte_kind_next == K_DATA) &&
                    (bit_index_next == 4'd0) && (sub_step_next == 2'd0) &&
                    !hold_valid_next;
    res.busy_res  = (phase_next != PH_IDLE);
    res.done_res  = done;
    res.status    = status;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      sub_step    <= 2'd0;
      bit_index   <= 4'd0;
      byte_kind   <= K_CTRLW;
      shift_reg   <= 8'd0;
      bytes_left  <= 16'd0;
      addr_reg    <= 16'd0;
      sel_reg     <= 3'd0;
      dir_reg     <= 1'b0;
      hold_byte   <= 8'd0;
      hold_valid  <= 1'b0;
      delay_count <= 8'd0;
      scl_reg     <= 1'b1;
      sda_reg     <= 1'b1;
      oe_reg      <= 1'b1;
      err_flag    <= 1'b0;
    end else if (step) begin
      phase       <= phase_next;
      sub_step    <= sub_step_next;
      bit_index   <= bit_index_next;
      byte_kind   <= byte_kind_next;
      shift_reg   <= shift_reg_next;
      bytes_left  <= bytes_left_next;
      addr_reg    <= addr_reg_next;
      sel_reg     <= sel_reg_next;
      dir_reg     <= dir_reg_next;
      hold_byte   <= hold_byte_next;
      hold_valid  <= hold_valid_next;
      delay_count <= delay_count_next;
      scl_reg     <= scl_reg_next;
      sda_reg     <= sda_reg_next;
      oe_reg      <= oe_reg_next;
      err_flag    <= err_flag_next;
    end
  end

endmodule

[rtl/core/i2cm_res_reg.sv]
// i2cm_res_reg: result register with valid/stall handshake towards the sink.
// Loads a new item whenever it is empty or being taken in the same cycle.
// Depends on i2cm_pkg.
module i2cm_res_reg import i2cm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load,
  input  res_item_t res_in,
  output logic      free,
  output logic      res_valid,
  input  logic      res_stall,
  output res_item_t res
);

  assign free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (free) begin
      res_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && free) begin
      res <= res_in;
    end
  end

endmodule

[rtl/core/i2c_eeprom_transaction_master.sv]
// An accepted item's result sits in the result register the next cycle.
// Throughput: one item per cycle; req_stall rises only while a result is held and stalled.
// Each tick runs one sequencer step; a bus slot lasts ticks_per_phase ticks, or one tick when it is 0.
// Reset (rst, synchronous, active high): idle, SCL and SDA high and driven,
// ticks_per_phase 2, control_code 10, result register empty.
// Depends on i2cm_pkg, i2cm_seq, i2cm_res_reg.
module i2c_eeprom_transaction_master import i2cm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_item_t             req,
  output logic                  res_valid,
  input  logic                  res_stall,
  output res_item_t             res,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] ticks_per_phase;
  logic [3:0] control_code;
  logic       free;
  logic       step;
  res_item_t  res_next;

  assign req_stall = !free;
  assign step      = req_valid && free;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_phase <= TICKS_RESET;
      control_code    <= CTRL_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_TICKS_PER_PHASE: ticks_per_phase <= cfg_data;
        CFG_CONTROL_CODE:    control_code    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  i2cm_seq u_seq (
    .clk             (clk),
    .rst             (rst),
    .step            (step),
    .req             (req),
    .ticks_per_phase (ticks_per_phase),
    .control_code    (control_code),
    .res             (res_next)
  );

  i2cm_res_reg u_res_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step),
    .res_in    (res_next),
    .free      (free),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

endmodule

[rtl/core/i2cm_checker.sv]
// i2cm_checker: port-level checks for the I2C EEPROM transaction master.
// Bound to the top level at the end of this file. Depends on i2cm_pkg.
module i2cm_checker import i2cm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  req_valid,
  input logic                  req_stall,
  input logic                  res_valid,
  input logic                  res_stall,
  input res_item_t             res
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result item changed while stalled");

  a_no_item_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !res_valid)
    else $error("result valid straight after reset");

  a_item_follows: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> res_valid)
    else $error("accepted item gave no result");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> res_valid && res_stall)
    else $error("input stalled with free result register");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.done_res || res.status) |-> res.done_res && !res.busy_res)
    else $error("done or status inconsistent with busy");

endmodule

bind i2c_eeprom_transaction_master i2cm_checker u_i2cm_checker (.*);

[dv/tb_i2c_eeprom_transaction_master.sv]
// Testbench for i2c_eeprom_transaction_master: a short table of items, then random
// transactions against an in-bench sequencer predictor, with random gaps and stalls.
// Depends on i2cm_pkg and the RTL under rtl/core.
module tb_i2c_eeprom_transaction_master;
  import i2cm_pkg::*;

  localparam logic [1:0] REQ_NOP = 2'd3;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam res_item_t IDLE_PINS  = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
  localparam res_item_t START_PINS = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};

  typedef enum logic [2:0] {S_IDLE, S_START, S_TX, S_TXACK, S_RX, S_MACK, S_STOP} seq_phase_t;
  typedef enum logic [2:0] {B_CTRLW, B_ADDRH, B_ADDRL, B_DATA, B_CTRLR} byte_kind_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_item_t             req = '0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  res_item_t             res;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  i2c_eeprom_transaction_master dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .res_valid(res_valid), .res_stall(res_stall), .res(res),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // sequencer predictor state
  logic [7:0]  m_tpp;
  logic [3:0]  m_code;
  seq_phase_t  m_phase;
  byte_kind_t  m_kind;
  logic [3:0]  m_bit;
  logic [1:0]  m_sub;
  logic [7:0]  m_shift, m_hold, m_delay;
  logic [15:0] m_left, m_addr;
  logic [2:0]  m_sel;
  logic        m_dir, m_hold_ok, m_scl, m_sda, m_oe, m_err;
  logic        o_rdv, o_done, o_status;
  logic [7:0]  o_rd;

  res_item_t   pins_due[$];
  req_item_t   table_items[$];
  bit          table_typed[$];
  res_item_t   table_want[$];

  int unsigned burst_left = 0;
  int unsigned stall_hold = 0;
  bit          force_nack = 1'b0;
  int          errors = 0;
  int          n_items = 0;
  int          n_checked = 0;
  int          n_read = 0;
  int          n_done = 0;
  int          n_nack = 0;
  res_item_t   due;

  function int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function void load_byte(input byte_kind_t k);
    m_kind = k;
    m_phase = S_TX;
    m_bit = 4'd0;
    m_sub = 2'd0;
    case (k)
      B_CTRLW, B_CTRLR: m_shift = {m_code, m_sel, (k == B_CTRLR)};
      B_ADDRH: m_shift = m_addr[15:8];
      B_ADDRL: m_shift = m_addr[7:0];
      default: ;
    endcase
  endfunction

  function void to_stop();
    m_phase = S_STOP;
    m_sub = 2'd0;
  endfunction

  function void to_rx();
    m_phase = S_RX;
    m_bit = 4'd0;
    m_sub = 2'd0;
    m_shift = 8'h00;
  endfunction

  function res_item_t sequencer_step(input req_item_t it);
    res_item_t  r;
    logic [8:0] slot_len;
    logic       moved;
    o_rdv = 1'b0;
    o_rd = 8'h00;
    o_done = 1'b0;
    o_status = 1'b0;
    if (it.req_type == REQ_START) begin
      if (m_phase == S_IDLE) begin
        m_sel = it.device_sel;
        m_addr = it.mem_addr;
        m_dir = it.is_read;
        m_left = it.byte_count;
        m_hold_ok = 1'b0;
        m_err = 1'b0;
        m_delay = 8'd0;
        m_bit = 4'd0;
        m_kind = B_CTRLW;
        m_phase = S_START;
        m_sub = 2'd0;
      end
    end else if (it.req_type == REQ_WDATA) begin
      if (m_phase != S_IDLE && !m_dir) begin
        m_hold = it.wr_byte;
        m_hold_ok = 1'b1;
      end
    end else if (it.req_type == REQ_TICK && m_phase != S_IDLE) begin
      slot_len = (m_tpp == 8'd0) ? 9'd1 : {1'b0, m_tpp};
      if ({1'b0, m_delay} + 9'd1 < slot_len) begin
        m_delay++;
      end else begin
        moved = 1'b1;
        case (m_phase)
          S_START: begin
            case (m_sub)
              2'd0: begin m_oe = 1'b1; m_sda = 1'b1; m_sub = 2'd1; end
              2'd1: begin m_scl = 1'b1; m_sub = 2'd2; end
              2'd2: begin m_sda = 1'b0; m_sub = 2'd3; end
              default: begin
                m_scl = 1'b0;
                load_byte((m_dir && m_kind == B_ADDRL) ? B_CTRLR : B_CTRLW);
              end
            endcase
          end
          S_TX: begin
            if (m_sub == 2'd0) begin
              if (m_bit == 4'd0 && m_kind == B_DATA && !m_hold_ok) begin
                moved = 1'b0;
              end else begin
                if (m_bit == 4'd0 && m_kind == B_DATA) begin
                  m_shift = m_hold;
                  m_hold_ok = 1'b0;
                  m_left--;
                end
                m_oe = 1'b1;
                m_sda = m_shift[7];
                m_sub = 2'd1;
              end
            end else if (m_sub == 2'd1) begin
              m_scl = 1'b1;
              m_sub = 2'd2;
            end else begin
              m_scl = 1'b0;
              m_shift = m_shift << 1;
              m_bit++;
              m_sub = 2'd0;
              if (m_bit >= 4'd8) begin
                m_phase = S_TXACK;
                m_bit = 4'd0;
              end
            end
          end
          S_TXACK: begin
            if (m_sub == 2'd0) begin
              m_oe = 1'b0;
              m_sub = 2'd1;
            end else if (m_sub == 2'd1) begin
              m_scl = 1'b1;
              m_sub = 2'd2;
            end else begin
              m_scl = 1'b0;
              if (it.sda_in) begin
                m_err = 1'b1;
                to_stop();
              end else begin
                case (m_kind)
                  B_CTRLW: load_byte(B_ADDRH);
                  B_ADDRH: load_byte(B_ADDRL);
                  B_ADDRL: begin
                    if (m_dir) begin
                      m_phase = S_START;
                      m_sub = 2'd0;
                    end else if (m_left == 16'd0) to_stop();
                    else load_byte(B_DATA);
                  end
                  B_DATA: begin
                    if (m_left == 16'd0) to_stop();
                    else load_byte(B_DATA);
                  end
                  default: begin
                    if (m_left == 16'd0) to_stop();
                    else to_rx();
                  end
                endcase
              end
            end
          end
          S_RX: begin
            if (m_sub == 2'd0) begin
              m_oe = 1'b0;
              m_sub = 2'd1;
            end else if (m_sub == 2'd1) begin
              m_scl = 1'b1;
              m_sub = 2'd2;
            end else begin
              m_shift = {m_shift[6:0], it.sda_in};
              m_scl = 1'b0;
              m_bit++;
              m_sub = 2'd0;
              if (m_bit >= 4'd8) begin
                o_rdv = 1'b1;
                o_rd = m_shift;
                m_left--;
                m_phase = S_MACK;
                m_bit = 4'd0;
              end
            end
          end
          S_MACK: begin
            if (m_sub == 2'd0) begin
              m_oe = 1'b1;
              m_sda = (m_left == 16'd0);
              m_sub = 2'd1;
            end else if (m_sub == 2'd1) begin
              m_scl = 1'b1;
              m_sub = 2'd2;
            end else begin
              m_scl = 1'b0;
              if (m_left == 16'd0) to_stop();
              else to_rx();
            end
          end
          S_STOP: begin
            if (m_sub == 2'd0) begin
              m_oe = 1'b1;
              m_sda = 1'b0;
              m_sub = 2'd1;
            end else if (m_sub == 2'd1) begin
              m_scl = 1'b1;
              m_sub = 2'd2;
            end else begin
              m_sda = 1'b1;
              m_phase = S_IDLE;
              m_sub = 2'd0;
              o_done = 1'b1;
              o_status = m_err;
            end
          end
          default: m_phase = S_IDLE;
        endcase
        m_delay = moved ? 8'd0 : 8'(slot_len - 9'd1);
      end
    end
    r.scl = m_scl;
    r.sda_drive = m_sda;
    r.sda_oe = m_oe;
    r.rd_valid = o_rdv;
    r.rd_byte = o_rd;
    r.need_data = (m_phase == S_TX && m_kind == B_DATA && m_bit == 4'd0 && m_sub == 2'd0
                   && !m_hold_ok);
    r.busy_res = (m_phase != S_IDLE);
    r.done_res = o_done;
    r.status = o_status;
    return r;
  endfunction

  function void add_row(input logic [1:0] kind, input logic sda, input logic [2:0] sel,
                        input logic [15:0] addr, input logic rd, input logic [15:0] cnt,
                        input logic [7:0] wb, input bit typed, input res_item_t want);
    req_item_t it;
    it = '{kind, sda, sel, addr, rd, cnt, wb};
    table_items.push_back(it);
    table_typed.push_back(typed);
    table_want.push_back(want);
  endfunction

  task report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  task check_field(input string name, input logic [7:0] got, input logic [7:0] want);
    if (got !== want)
      report_mismatch($sformatf("result %0d %s got %0h want %0h", n_checked, name, got, want));
  endtask

  task send_item(input req_item_t it, input bit typed, input res_item_t want);
    int unsigned gap;
    res_item_t   pred;
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      gap = gap_len();
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pred = sequencer_step(it);
    pins_due.push_back(typed ? want : pred);
    n_items++;
  endtask

  task drain_results();
    req_valid <= 1'b0;
    while (pins_due.size() != 0) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain_results();
    repeat (2) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_TICKS_PER_PHASE) m_tpp = val;
    else m_code = val[3:0];
  endtask

  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_hold <= 0;
    end else if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else begin
      res_stall <= ($urandom_range(0, 2) == 0);
      stall_hold <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (pins_due.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        due = pins_due.pop_front();
        check_field("scl", 8'(res.scl), 8'(due.scl));
        check_field("sda_drive", 8'(res.sda_drive), 8'(due.sda_drive));
        check_field("sda_oe", 8'(res.sda_oe), 8'(due.sda_oe));
        check_field("rd_valid", 8'(res.rd_valid), 8'(due.rd_valid));
        check_field("rd_byte", res.rd_byte, due.rd_byte);
        check_field("need_data", 8'(res.need_data), 8'(due.need_data));
        check_field("busy_res", 8'(res.busy_res), 8'(due.busy_res));
        check_field("done_res", 8'(res.done_res), 8'(due.done_res));
        check_field("status", 8'(res.status), 8'(due.status));
        n_checked++;
        if (due.rd_valid) n_read++;
        if (due.done_res) n_done++;
        if (due.done_res && due.status) n_nack++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || cfg_wr_en || (req_valid && !req_stall) || (res_valid && !res_stall)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [7:0]  slot_ticks [4];
    int          phase_len [4];
    req_item_t   it;
    int unsigned r;
    slot_ticks = '{8'd1, 8'd255, 8'd0, 8'd3};
    phase_len = '{130, 30, 130, 80};

    m_tpp = TICKS_RESET;
    m_code = CTRL_RESET;
    m_phase = S_IDLE;
    m_kind = B_CTRLW;
    m_bit = '0;
    m_sub = '0;
    m_shift = '0;
    m_hold = '0;
    m_delay = '0;
    m_left = '0;
    m_addr = '0;
    m_sel = '0;
    m_dir = 1'b0;
    m_hold_ok = 1'b0;
    m_scl = 1'b1;
    m_sda = 1'b1;
    m_oe = 1'b1;
    m_err = 1'b0;

    // idle noise, an extreme start, an ignored start, a replaced write byte
    add_row(REQ_NOP, 1'b1, 3'd7, 16'hFFFF, 1'b1, 16'hFFFF, 8'hFF, 1'b1, IDLE_PINS);
    add_row(REQ_TICK, 1'b1, 3'd0, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b1, IDLE_PINS);
    add_row(REQ_WDATA, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 8'hFF, 1'b1, IDLE_PINS);
    add_row(REQ_START, 1'b0, 3'd7, 16'hFFFF, 1'b0, 16'd1, 8'h00, 1'b1, START_PINS);
    add_row(REQ_START, 1'b1, 3'd0, 16'h0000, 1'b1, 16'hFFFF, 8'hFF, 1'b1, START_PINS);
    add_row(REQ_WDATA, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b1, START_PINS);
    add_row(REQ_WDATA, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 8'hA5, 1'b1, START_PINS);
    add_row(REQ_NOP, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b1, START_PINS);
    for (int i = 0; i < 16; i++)
      add_row(REQ_TICK, 1'b0, 3'd0, 16'h0000, 1'b0, 16'h0000, 8'h00, 1'b0, '0);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < table_items.size(); i++)
      send_item(table_items[i], table_typed[i], table_want[i]);

    for (int p = 0; p < 4; p++) begin
      write_reg(CFG_TICKS_PER_PHASE, slot_ticks[p]);
      write_reg(CFG_CONTROL_CODE, (p == 1) ? 8'd15 : (p == 2) ? 8'd0 : 8'($urandom_range(0, 15)));
      for (int n = 0; n < phase_len[p]; n++) begin
        if (n == phase_len[p] / 2) drain_results();
        it.sda_in = 1'($urandom_range(0, 1));
        it.device_sel = 3'($urandom_range(0, 7));
        it.mem_addr = 16'($urandom_range(0, 65535));
        it.is_read = 1'($urandom_range(0, 1));
        it.byte_count = 16'($urandom_range(0, 65535));
        it.wr_byte = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (m_phase == S_IDLE) begin
          if (r < 80) begin
            it.req_type = REQ_START;
            r = $urandom_range(0, 99);
            force_nack = (r >= 94);
            if (r < 80) it.byte_count = 16'($urandom_range(0, 3));
            else if (r < 94) it.byte_count = 16'($urandom_range(4, 6));
            else if (r < 97) it.byte_count = 16'hFFFF;
          end else if (r < 87) it.req_type = REQ_TICK;
          else if (r < 94) it.req_type = REQ_WDATA;
          else it.req_type = REQ_NOP;
        end else if (m_phase == S_TX && m_kind == B_DATA && m_bit == 4'd0 && m_sub == 2'd0
                     && !m_hold_ok) begin
          it.req_type = (r < 85) ? REQ_WDATA : REQ_TICK;
        end else begin
          if (r < 88) it.req_type = REQ_TICK;
          else if (r < 92) it.req_type = REQ_WDATA;
          else if (r < 96) it.req_type = REQ_START;
          else it.req_type = REQ_NOP;
        end
        // slave acknowledges mostly; long transfers are cut short by a NACK
        if (it.req_type == REQ_TICK && m_phase == S_TXACK)
          it.sda_in = force_nack || ($urandom_range(0, 19) == 0);
        send_item(it, 1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk);
    $display("Run: %0d items, %0d results checked, %0d bytes read, %0d transactions closed",
             n_items, n_checked, n_read, n_done);
    $display("(%0d on a missing acknowledge), slot lengths 0, 1, 2, 3 and 255 ticks.", n_nack);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
